### hdl/mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    localparam int WORD_W      = 32;
    localparam int STEP_W      = 31;
    localparam int MAG_W       = 31;
    localparam int LIMIT_W     = 16;
    localparam int PIX_W       = 12;
    localparam int COUNT_OUT_W = 16;
    localparam int CFG_IDX_W   = 3;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 28;
    localparam int DEF_ITER_BITS  = 16;

    localparam logic signed [WORD_W-1:0] RST_X_ORIGIN = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] RST_Y_ORIGIN = -32'sd402653184;
    localparam logic [STEP_W-1:0]        RST_X_STEP   = 31'd786432;
    localparam logic [STEP_W-1:0]        RST_Y_STEP   = 31'd786432;
    localparam logic [MAG_W-1:0]         RST_ESC_R    = 31'd1073741824;
    localparam logic [LIMIT_W-1:0]       RST_MAX_ITER = 16'd1000;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_ESC_R    = 3'd4,
        CFG_MAX_ITER = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INIT = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EVAL = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_pix;
        logic init;
        logic mul;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cont;
    } sts_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX[WORD_W-1:0];
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN[WORD_W-1:0];
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/mbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire mbe_pkg::sts_t sts,
    output mbe_pkg::cmd_t      cmd
);

    mbe_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == mbe_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            mbe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = mbe_pkg::ST_INIT;
                end
            end
            mbe_pkg::ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = mbe_pkg::ST_MUL;
            end
            mbe_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = mbe_pkg::ST_EVAL;
            end
            mbe_pkg::ST_EVAL:
            begin
                if (sts.cont)
                begin
                    cmd.step   = 1'b1;
                    state_next = mbe_pkg::ST_MUL;
                end
                else if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result word overwritten while pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again while busy");

endmodule

`default_nettype wire

### hdl/mbe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath #(
    parameter int COORD_BITS = mbe_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS,
    parameter int ITER_BITS  = mbe_pkg::DEF_ITER_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire mbe_pkg::cmd_t                          cmd,
    output mbe_pkg::sts_t                               sts,
    input  wire logic [mbe_pkg::PIX_W-1:0]              pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]              pixel_y,
    input  wire logic signed [mbe_pkg::WORD_W-1:0]      x_origin,
    input  wire logic signed [mbe_pkg::WORD_W-1:0]      y_origin,
    input  wire logic [mbe_pkg::STEP_W-1:0]             x_step,
    input  wire logic [mbe_pkg::STEP_W-1:0]             y_step,
    input  wire logic [mbe_pkg::MAG_W-1:0]              escape_radius_sq,
    input  wire logic [mbe_pkg::LIMIT_W-1:0]            max_iterations,
    output logic [mbe_pkg::COUNT_OUT_W-1:0]             iteration_count,
    output logic                                        inside_set,
    output logic [mbe_pkg::MAG_W-1:0]                   final_magnitude_sq
);

    localparam int W      = mbe_pkg::WORD_W;
    localparam int PROD_W = 2 * W;
    localparam int CP_W   = mbe_pkg::STEP_W + COORD_BITS;
    localparam int CS_W   = CP_W + 2;

    logic [COORD_BITS-1:0]      px_reg, py_reg;
    logic signed [W-1:0]        cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [PROD_W-1:0]   p_rr_reg, p_ii_reg, p_ri_reg;
    logic [ITER_BITS-1:0]       count_reg;
    logic [ITER_BITS-1:0]       limit;

    logic [CP_W-1:0]            cx_prod, cy_prod;
    logic signed [CS_W-1:0]     cx_sum, cy_sum;
    logic signed [W-1:0]        sq_rr, sq_ii, x_ri;
    logic [W-1:0]               mag_sum;
    logic [mbe_pkg::MAG_W-1:0]  mag;
    logic signed [W+1:0]        nr_sum, ni_sum;

    logic [mbe_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic                            out_inside_reg;
    logic [mbe_pkg::MAG_W-1:0]       out_mag_reg;

    assign limit = ITER_BITS'(max_iterations);

    assign cx_prod = CP_W'(x_step) * CP_W'(px_reg);
    assign cy_prod = CP_W'(y_step) * CP_W'(py_reg);
    assign cx_sum  = $signed({{(CS_W-W){x_origin[W-1]}}, x_origin})
                   + $signed({2'b00, cx_prod});
    assign cy_sum  = $signed({{(CS_W-W){y_origin[W-1]}}, y_origin})
                   + $signed({2'b00, cy_prod});

    assign sq_rr = mbe_pkg::sat_word(p_rr_reg >>> FRAC_BITS);
    assign sq_ii = mbe_pkg::sat_word(p_ii_reg >>> FRAC_BITS);
    assign x_ri  = mbe_pkg::sat_word(p_ri_reg >>> (FRAC_BITS - 1));

    assign mag_sum = $unsigned(sq_rr) + $unsigned(sq_ii);
    assign mag     = mag_sum[W-1] ? '1 : mag_sum[mbe_pkg::MAG_W-1:0];

    assign nr_sum = {{2{sq_rr[W-1]}}, sq_rr} - {{2{sq_ii[W-1]}}, sq_ii}
                  + {{2{cr_reg[W-1]}}, cr_reg};
    assign ni_sum = {{2{x_ri[W-1]}}, x_ri} + {{2{ci_reg[W-1]}}, ci_reg};

    assign sts.cont = (mag < escape_radius_sq) && (count_reg < limit);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            px_reg <= COORD_BITS'(pixel_x);
            py_reg <= COORD_BITS'(pixel_y);
        end
        if (cmd.init)
        begin
            cr_reg    <= mbe_pkg::sat_word(64'(cx_sum));
            ci_reg    <= mbe_pkg::sat_word(64'(cy_sum));
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (cmd.mul)
        begin
            p_rr_reg <= PROD_W'(zr_reg) * PROD_W'(zr_reg);
            p_ii_reg <= PROD_W'(zi_reg) * PROD_W'(zi_reg);
            p_ri_reg <= PROD_W'(zr_reg) * PROD_W'(zi_reg);
        end
        if (cmd.step)
        begin
            zr_reg    <= mbe_pkg::sat_word(64'(nr_sum));
            zi_reg    <= mbe_pkg::sat_word(64'(ni_sum));
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_count_reg  <= mbe_pkg::COUNT_OUT_W'(count_reg);
            out_inside_reg <= (count_reg >= limit);
            out_mag_reg    <= mag;
        end
    end

    assign iteration_count    = out_count_reg;
    assign inside_set         = out_inside_reg;
    assign final_magnitude_sq = out_mag_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (count_reg < limit))
        else $error("iteration stepped past the limit");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> (zr_reg == '0 && zi_reg == '0 && count_reg == '0))
        else $error("z or count not cleared on start");

endmodule

`default_nettype wire

### hdl/mandelbrot_escape_iteration_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Mandelbrot escape-time unit: each input word carries a pixel column and row;
// the unit forms c = origin + step * coordinate and iterates z = z*z + c in
// saturating Q4.28 until |z|^2 reaches escape_radius_sq or the count reaches
// max_iterations, then returns one word with the count, the inside flag and the
// last |z|^2. Each item is worked in steps: first c is formed, then each pass of
// the iteration loop has a multiply stage for zr*zr, zi*zi, zr*zi, then a
// saturate and add stage that tests escape and updates z, with one final pass
// that only tests and waits until the output register is free. One pixel is in
// work at a time; a finished word waits in the output register while the next
// pixel is taken. Write the configuration registers through cfg_wen /
// cfg_index / cfg_data only while the unit is idle; the unit does not enforce this.
module mandelbrot_escape_iteration_unit #(
    parameter int COORD_BITS = mbe_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = mbe_pkg::DEF_FRAC_BITS,
    parameter int ITER_BITS  = mbe_pkg::DEF_ITER_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wen,
    input  wire logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mbe_pkg::WORD_W-1:0]        cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // pixel_x, pixel_y
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [47:0]                            m_axis_tdata,  // iteration_count, final_magnitude_sq
    output logic                                   m_axis_tuser   // inside_set
);

    logic signed [mbe_pkg::WORD_W-1:0] x_origin_reg, y_origin_reg;
    logic [mbe_pkg::STEP_W-1:0]        x_step_reg, y_step_reg;
    logic [mbe_pkg::MAG_W-1:0]         esc_r_reg;
    logic [mbe_pkg::LIMIT_W-1:0]       max_iter_reg;

    mbe_pkg::cmd_t cmd;
    mbe_pkg::sts_t sts;

    logic [mbe_pkg::COUNT_OUT_W-1:0] iteration_count;
    logic                            inside_set;
    logic [mbe_pkg::MAG_W-1:0]       final_magnitude_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= mbe_pkg::RST_X_ORIGIN;
            y_origin_reg <= mbe_pkg::RST_Y_ORIGIN;
            x_step_reg   <= mbe_pkg::RST_X_STEP;
            y_step_reg   <= mbe_pkg::RST_Y_STEP;
            esc_r_reg    <= mbe_pkg::RST_ESC_R;
            max_iter_reg <= mbe_pkg::RST_MAX_ITER;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                mbe_pkg::CFG_X_ORIGIN: x_origin_reg <= $signed(cfg_data);
                mbe_pkg::CFG_Y_ORIGIN: y_origin_reg <= $signed(cfg_data);
                mbe_pkg::CFG_X_STEP:   x_step_reg   <= cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_Y_STEP:   y_step_reg   <= cfg_data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_ESC_R:    esc_r_reg    <= cfg_data[mbe_pkg::MAG_W-1:0];
                mbe_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[mbe_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mbe_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .pixel_x            (s_axis_tdata[11:0]),
        .pixel_y            (s_axis_tdata[23:12]),
        .x_origin           (x_origin_reg),
        .y_origin           (y_origin_reg),
        .x_step             (x_step_reg),
        .y_step             (y_step_reg),
        .escape_radius_sq   (esc_r_reg),
        .max_iterations     (max_iter_reg),
        .iteration_count    (iteration_count),
        .inside_set         (inside_set),
        .final_magnitude_sq (final_magnitude_sq)
    );

    assign m_axis_tdata = {1'b0, final_magnitude_sq, iteration_count};
    assign m_axis_tuser = inside_set;

endmodule

`default_nettype wire
